/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hw/rtl/kti_pkg.sv */
// ----------------------------------------------------------------------------
// kti_pkg
// shared types and constants of the nearest-neighbour list keeper
// ----------------------------------------------------------------------------
package kti_pkg;

  localparam int unsigned MAX_K_DEF       = 16;
  localparam int unsigned NUM_QUERIES_DEF = 8;
  localparam int unsigned DUMP_LIMIT      = 16;

  localparam int unsigned DIST_W  = 40;
  localparam int unsigned IDX_W   = 24;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned K_W     = 5;
  localparam int unsigned RANK_W  = 4;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_COORD = 2'd1;
  localparam logic [1:0] OP_DUMP  = 2'd2;

  typedef enum logic [1:0] {
    WS_EMPTY,
    WS_CAND,
    WS_SHIFT
  } wsel_e;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  typedef struct packed {
    logic  load;
    logic  sq_en;
    logic  acc_en;
    logic  acc_last;
    logic  acc_clr;
    logic  rd_en;
    logic  wr_en;
    wsel_e wsel;
    logic  dump;
    logic  dump_last;
  } cmd_t;

endpackage

/* hw/rtl/kti_datapath.sv */
// ----------------------------------------------------------------------------
// kti_datapath
// distance accumulation, list memory, compare and result registers
// ----------------------------------------------------------------------------
module kti_datapath #(
  parameter int unsigned MAX_K       = kti_pkg::MAX_K_DEF,
  parameter int unsigned NUM_QUERIES = kti_pkg::NUM_QUERIES_DEF,
  parameter int unsigned KW          = 4,
  parameter int unsigned SW          = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kti_pkg::cmd_t                   cmd_i,
  input  logic [SW-1:0]                   slot_i,
  input  logic [KW-1:0]                   pos_i,
  input  logic [kti_pkg::IDX_W-1:0]       train_index_i,
  input  logic signed [kti_pkg::COORD_W-1:0] train_coord_i,
  input  logic signed [kti_pkg::COORD_W-1:0] test_coord_i,
  output logic                            cand_lt_o,
  output logic                            result_valid_o,
  output logic [kti_pkg::RANK_W-1:0]      rank_o,
  output logic [kti_pkg::DIST_W-1:0]      neighbor_distance_o,
  output logic [kti_pkg::IDX_W-1:0]       neighbor_index_o,
  output logic                            entry_filled_o,
  output logic                            last_o
);
  import kti_pkg::*;

  localparam int unsigned DEPTH = NUM_QUERIES * MAX_K;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t mem [DEPTH];

  logic [IDX_W-1:0]          idx_q;
  logic signed [COORD_W-1:0] tc_q, qc_q;
  logic [SQ_W-1:0]           sq_q;
  logic [DIST_W-1:0]         acc_q, cand_q;
  entry_t                    rdata_q;
  logic                      strobe_q, dlast_q;
  logic [RANK_W-1:0]         rank_q;

  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          mag17;
  logic [COORD_W-1:0]        mag;
  logic [DIST_W:0]           sum;
  logic [DIST_W-1:0]         sat;
  logic [AW-1:0]             addr;
  entry_t                    wdata;

  assign diff  = {tc_q[COORD_W-1], tc_q} - {qc_q[COORD_W-1], qc_q};
  assign mag17 = diff[COORD_W] ? 17'(-diff) : 17'(diff);
  assign mag   = mag17[COORD_W-1:0];
  assign sum   = {1'b0, acc_q} + (DIST_W+1)'(sq_q);
  assign sat   = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
  assign addr  = AW'(slot_i) * AW'(MAX_K) + AW'(pos_i);

  always_comb begin
    unique case (cmd_i.wsel)
      WS_EMPTY: wdata = '{distance: '1, idx: '0};
      WS_CAND:  wdata = '{distance: cand_q, idx: idx_q};
      WS_SHIFT: wdata = rdata_q;
      default:  wdata = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr];
    end
    if (cmd_i.load) begin
      idx_q <= train_index_i;
      tc_q  <= train_coord_i;
      qc_q  <= test_coord_i;
    end
    if (cmd_i.sq_en) begin
      sq_q <= mag * mag;
    end
    if (cmd_i.acc_en && cmd_i.acc_last) begin
      cand_q <= sat;
    end
    rank_q <= RANK_W'(pos_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      strobe_q <= 1'b0;
      dlast_q  <= 1'b0;
    end else begin
      if (cmd_i.acc_clr || (cmd_i.acc_en && cmd_i.acc_last)) begin
        acc_q <= '0;
      end else if (cmd_i.acc_en) begin
        acc_q <= sat;
      end
      strobe_q <= cmd_i.dump;
      dlast_q  <= cmd_i.dump_last;
    end
  end

  assign cand_lt_o           = cand_q < rdata_q.distance;
  assign result_valid_o      = strobe_q;
  assign rank_o              = rank_q;
  assign neighbor_distance_o = rdata_q.distance;
  assign neighbor_index_o    = rdata_q.idx;
  assign entry_filled_o      = rdata_q.distance != '1;
  assign last_o              = dlast_q;

endmodule

/* hw/rtl/kti_ctrl.sv */
// ----------------------------------------------------------------------------
// kti_ctrl
// sequencer for reset sweep, clear, accumulate, insertion and dump
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kti_ctrl #(
  parameter int unsigned MAX_K       = kti_pkg::MAX_K_DEF,
  parameter int unsigned NUM_QUERIES = kti_pkg::NUM_QUERIES_DEF,
  parameter int unsigned KW          = 4,
  parameter int unsigned SW          = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              op_i,
  input  logic [2:0]              query_slot_i,
  input  logic                    last_coord_i,
  input  logic                    cfg_we_i,
  input  logic [kti_pkg::K_W-1:0] cfg_wdata_i,
  input  logic                    cand_lt_i,
  output kti_pkg::cmd_t           cmd_o,
  output logic [SW-1:0]           slot_o,
  output logic [KW-1:0]           pos_o
);
  import kti_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_SQ,
    S_ACC,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_DUMP
  } state_e;

  state_e          state_q;
  logic [SW-1:0]   slot_q;
  logic [KW-1:0]   pos_q, keff_m1, dump_end;
  logic            first_q, last_q;
  logic [K_W-1:0]  k_q;
  logic            accept, slot_ok;

  assign busy    = state_q != S_IDLE;
  assign accept  = start && !busy;
  assign slot_ok = 32'(query_slot_i) < NUM_QUERIES;
  assign slot_o  = slot_q;

  always_comb begin
    if (k_q == '0) begin
      keff_m1 = '0;
    end else if (32'(k_q) > MAX_K) begin
      keff_m1 = KW'(MAX_K - 1);
    end else begin
      keff_m1 = KW'(k_q - K_W'(1));
    end
    dump_end = (32'(keff_m1) > DUMP_LIMIT - 1) ? KW'(DUMP_LIMIT - 1) : keff_m1;
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.wsel = WS_EMPTY;
    cmd_o.load = accept;
    pos_o      = pos_q;
    unique case (state_q)
      S_INIT, S_CLR: begin
        cmd_o.wr_en = 1'b1;
      end
      S_IDLE: begin
        cmd_o.acc_clr = accept && slot_ok && (op_i == OP_CLEAR);
      end
      S_SQ: begin
        cmd_o.sq_en = 1'b1;
      end
      S_ACC: begin
        cmd_o.acc_en   = 1'b1;
        cmd_o.acc_last = last_q;
      end
      S_INS_RD: begin
        cmd_o.rd_en = 1'b1;
        pos_o       = first_q ? pos_q : pos_q - KW'(1);
      end
      S_INS_CMP: begin
        cmd_o.wr_en = !first_q && cand_lt_i;
        cmd_o.wsel  = WS_SHIFT;
      end
      S_INS_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = WS_CAND;
      end
      S_DUMP: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.dump      = 1'b1;
        cmd_o.dump_last = pos_q == dump_end;
      end
      default: begin
        cmd_o.load = accept;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      slot_q  <= '0;
      pos_q   <= '0;
      first_q <= 1'b0;
      last_q  <= 1'b0;
      k_q     <= K_W'(16);
    end else begin
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_INIT: begin
          pos_q <= pos_q + KW'(1);
          if (pos_q == KW'(MAX_K - 1)) begin
            pos_q <= '0;
            if (slot_q == SW'(NUM_QUERIES - 1)) begin
              state_q <= S_IDLE;
            end else begin
              slot_q <= slot_q + SW'(1);
            end
          end
        end
        S_IDLE: begin
          if (accept && slot_ok) begin
            slot_q <= SW'(query_slot_i);
            last_q <= last_coord_i;
            pos_q  <= '0;
            unique case (op_i)
              OP_CLEAR: state_q <= S_CLR;
              OP_COORD: state_q <= S_SQ;
              OP_DUMP:  state_q <= S_DUMP;
              default:  state_q <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          pos_q <= pos_q + KW'(1);
          if (pos_q == KW'(MAX_K - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_SQ: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (last_q) begin
            pos_q   <= keff_m1;
            first_q <= 1'b1;
            state_q <= S_INS_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_INS_RD: begin
          state_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (first_q) begin
            first_q <= 1'b0;
            if (!cand_lt_i) begin
              state_q <= S_IDLE;
            end else if (pos_q == '0) begin
              state_q <= S_INS_WR;
            end else begin
              state_q <= S_INS_RD;
            end
          end else if (cand_lt_i) begin
            pos_q   <= pos_q - KW'(1);
            state_q <= (pos_q == KW'(1)) ? S_INS_WR : S_INS_RD;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          state_q <= S_IDLE;
        end
        S_DUMP: begin
          pos_q <= pos_q + KW'(1);
          if (pos_q == dump_end) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_rd_wr_excl, clk_i, rst_ni, !(cmd_o.rd_en && cmd_o.wr_en))
  `ASSERT_IMPLY(a_dump_last, clk_i, rst_ni, cmd_o.dump_last, cmd_o.dump)
  `ASSERT_IMPLY(a_idle_quiet, clk_i, rst_ni, state_q == S_IDLE, !cmd_o.wr_en && !cmd_o.rd_en)
  `ASSERT_IMPLY(a_shift_nonzero, clk_i, rst_ni, cmd_o.wr_en && cmd_o.wsel == WS_SHIFT, pos_q != '0)

endmodule

/* hw/rtl/knn_distance_topk_insert_top.sv */
// busy stays high for a coordinate item through the square and accumulate states;
// a last-dimension item adds the insertion walk, a read and a compare per entry
// visited and a write if the candidate enters. a dump gives one result per cycle;
// a clear empties MAX_K entries. the insertion walk over the single-port list memory
// sets the worst-case rate. after reset a sweep empties every list with busy high;
// results are strobed for one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// knn_distance_topk_insert_top
// sorted nearest-neighbour lists with squared distance accumulation
// ----------------------------------------------------------------------------
module knn_distance_topk_insert_top #(
  parameter int unsigned MAX_K       = kti_pkg::MAX_K_DEF,
  parameter int unsigned NUM_QUERIES = kti_pkg::NUM_QUERIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op_i,
  input  logic [2:0]                         query_slot_i,
  input  logic [kti_pkg::IDX_W-1:0]          train_index_i,
  input  logic signed [kti_pkg::COORD_W-1:0] train_coord_i,
  input  logic signed [kti_pkg::COORD_W-1:0] test_coord_i,
  input  logic                               last_coord_i,
  input  logic                               cfg_we_i,
  input  logic [kti_pkg::K_W-1:0]            cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [kti_pkg::RANK_W-1:0]         rank_o,
  output logic [kti_pkg::DIST_W-1:0]         neighbor_distance_o,
  output logic [kti_pkg::IDX_W-1:0]          neighbor_index_o,
  output logic                               entry_filled_o,
  output logic                               last_o
);
  import kti_pkg::*;

  localparam int unsigned KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned SW = (NUM_QUERIES > 1) ? $clog2(NUM_QUERIES) : 1;

  cmd_t          cmd;
  logic [SW-1:0] slot;
  logic [KW-1:0] pos;
  logic          cand_lt;

  kti_ctrl #(
    .MAX_K(MAX_K), .NUM_QUERIES(NUM_QUERIES), .KW(KW), .SW(SW)
  ) u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .op_i, .query_slot_i, .last_coord_i,
    .cfg_we_i, .cfg_wdata_i,
    .cand_lt_i (cand_lt),
    .cmd_o     (cmd),
    .slot_o    (slot),
    .pos_o     (pos)
  );

  kti_datapath #(
    .MAX_K(MAX_K), .NUM_QUERIES(NUM_QUERIES), .KW(KW), .SW(SW)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .slot_i    (slot),
    .pos_i     (pos),
    .train_index_i, .train_coord_i, .test_coord_i,
    .cand_lt_o (cand_lt),
    .result_valid_o, .rank_o, .neighbor_distance_o, .neighbor_index_o,
    .entry_filled_o, .last_o
  );

endmodule
